>>> src/hcv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hcv_pkg;

  // fixed point widths of the trigonometric part
  localparam int TW        = 34;
  localparam int TRIG_FRAC = 30;
  localparam int SC_W      = 32;
  localparam int POS_FRAC  = 10;

  // curvature constants
  localparam int CST_W = 29;
  localparam logic [CST_W-1:0] LUT_CONST    = 29'd437209131;
  localparam logic [CST_W-1:0] PRELUT_CONST = 29'd200;

  // field register
  localparam int FIELD_W = 24;
  localparam logic [FIELD_W-1:0] FIELD_RESET = 24'd65536;

  // input kind codes
  localparam logic KIND_PRELUT = 1'b0;
  localparam logic KIND_LUT    = 1'b1;

  // quotient width, one guard bit for overflow
  localparam int Q_W = 33;

  typedef logic signed [TW-1:0] trig_t;

  localparam trig_t TRIG_ONE = 34'sd1073741824;
  localparam logic [2*TW-1:0] MULQ_RND = (2*TW)'(1) << (TRIG_FRAC - 1);

  // sine polynomial coefficients, Q30
  function automatic trig_t sin_coef(input logic [2:0] i);
    trig_t r;
    case (i)
      3'd0:    r = 34'sd1686629713;
      3'd1:    r = 34'sd693598669;
      3'd2:    r = 34'sd85569306;
      3'd3:    r = 34'sd5026991;
      3'd4:    r = 34'sd172272;
      3'd5:    r = 34'sd3864;
      default: r = '0;
    endcase
    return r;
  endfunction

  // cosine polynomial coefficients, Q30
  function automatic trig_t cos_coef(input logic [2:0] i);
    trig_t r;
    case (i)
      3'd0:    r = 34'sd1324675883;
      3'd1:    r = 34'sd272375562;
      3'd2:    r = 34'sd22401992;
      3'd3:    r = 34'sd987048;
      3'd4:    r = 34'sd27060;
      3'd5:    r = 34'sd506;
      default: r = '0;
    endcase
    return r;
  endfunction

  // q30 product, rounded to nearest with ties away from zero
  function automatic trig_t mulq(input trig_t a, input trig_t b);
    logic [TW-1:0]   ma;
    logic [TW-1:0]   mb;
    logic [2*TW-1:0] p;
    logic [TW-1:0]   r;
    logic            neg;
    neg = a[TW-1] ^ b[TW-1];
    ma  = a[TW-1] ? TW'(-a) : TW'(a);
    mb  = b[TW-1] ? TW'(-b) : TW'(b);
    p   = (2*TW)'(ma) * (2*TW)'(mb);
    p   = p + MULQ_RND;
    r   = p[TRIG_FRAC +: TW];
    return neg ? trig_t'(-r) : trig_t'(r);
  endfunction

endpackage

`default_nettype wire

>>> src/hough_curve_value_core.sv
// channel   direction  handshake              payload
// in        input      in_valid_i/in_stall_o  kind_i, transverse_pos_i, beam_pos_i, angle_i
// out       output     out_valid_o/out_stall_i curve_value_o, saturated_o
// cfg       input      cfg_valid_i/cfg_ready_o cfg_data_i (field_strength)
//
// one request per cycle while the output does not stall: 7 trig stages, 6 multiply
// stages and 34 division stages, the last being the output register
// the division costs one stage per quotient bit
// reset clears all valid bits and loads the field register with 1 T
// a stall holds the final stage, upstream bubbles still fill
`timescale 1ns / 1ps
`default_nettype none

module hough_curve_value_core import hcv_pkg::*; #(
  parameter int POS_BITS         = 22,
  parameter int ANGLE_BITS       = 16,
  parameter int RESULT_FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         kind_i,
  input  logic signed [POS_BITS-1:0]   transverse_pos_i,
  input  logic signed [POS_BITS-1:0]   beam_pos_i,
  input  logic signed [ANGLE_BITS-1:0] angle_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [31:0]           curve_value_o,
  output logic                         saturated_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [FIELD_W-1:0]           cfg_data_i
);

  localparam int PW    = POS_BITS + SC_W;
  localparam int NW    = PW + 1;
  localparam int HW    = (NW + 1) / 2;
  localparam int SHIFT = TRIG_FRAC + POS_FRAC + RESULT_FRAC_BITS;
  localparam int XW    = 2 * HW + CST_W + SHIFT;
  localparam int YW    = 4 * HW + FIELD_W;

  logic [FIELD_W-1:0] field_q;

  logic                       tr_v, tr_rdy, tr_kind;
  logic signed [POS_BITS-1:0] tr_t, tr_z;
  logic signed [SC_W-1:0]     tr_s, tr_c;
  logic                       in_rdy;

  logic                ar_v, ar_rdy, ar_neg, ar_nz, ar_yz;
  logic [XW-1:0]       ar_x;
  logic [YW-1:0]       ar_y;
  logic                dv_rdy;
  logic [31:0]         res;

  // field register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q <= FIELD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      field_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  hcv_trig #(
    .POS_BITS   (POS_BITS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_trig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .v_i     (in_valid_i),
    .rdy_o   (in_rdy),
    .kind_i  (kind_i),
    .t_i     (transverse_pos_i),
    .z_i     (beam_pos_i),
    .angle_i (angle_i),
    .v_o     (tr_v),
    .rdy_i   (tr_rdy),
    .kind_o  (tr_kind),
    .t_o     (tr_t),
    .z_o     (tr_z),
    .s_o     (tr_s),
    .c_o     (tr_c)
  );

  hcv_arith #(
    .POS_BITS         (POS_BITS),
    .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
  ) u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .field_i (field_q),
    .v_i     (tr_v),
    .rdy_o   (tr_rdy),
    .kind_i  (tr_kind),
    .t_i     (tr_t),
    .z_i     (tr_z),
    .s_i     (tr_s),
    .c_i     (tr_c),
    .v_o     (ar_v),
    .rdy_i   (ar_rdy),
    .x_o     (ar_x),
    .y_o     (ar_y),
    .neg_o   (ar_neg),
    .nz_o    (ar_nz),
    .yz_o    (ar_yz)
  );

  hcv_div #(
    .XW (XW),
    .YW (YW)
  ) u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .v_i           (ar_v),
    .rdy_o         (ar_rdy),
    .x_i           (ar_x),
    .y_i           (ar_y),
    .neg_i         (ar_neg),
    .nz_i          (ar_nz),
    .yz_i          (ar_yz),
    .v_o           (out_valid_o),
    .rdy_i         (dv_rdy),
    .curve_value_o (res),
    .saturated_o   (saturated_o)
  );

  assign dv_rdy        = ~out_stall_i;
  assign in_stall_o    = ~in_rdy;
  assign curve_value_o = signed'(res);

endmodule

`default_nettype wire

>>> src/hcv_trig.sv
`timescale 1ns / 1ps
`default_nettype none

module hcv_trig import hcv_pkg::*; #(
  parameter int POS_BITS   = 22,
  parameter int ANGLE_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       v_i,
  output logic                       rdy_o,
  input  logic                       kind_i,
  input  logic signed [POS_BITS-1:0]   t_i,
  input  logic signed [POS_BITS-1:0]   z_i,
  input  logic signed [ANGLE_BITS-1:0] angle_i,
  output logic                       v_o,
  input  logic                       rdy_i,
  output logic                       kind_o,
  output logic signed [POS_BITS-1:0]   t_o,
  output logic signed [POS_BITS-1:0]   z_o,
  output logic signed [SC_W-1:0]       s_o,
  output logic signed [SC_W-1:0]       c_o
);

  localparam int NST = 7;

  logic [NST-1:0] v_q;
  logic [NST-1:0] rdy;

  logic                       kind_q [0:NST-1];
  logic signed [POS_BITS-1:0] t_q    [0:NST-1];
  logic signed [POS_BITS-1:0] z_q    [0:NST-1];
  trig_t                      u_q    [0:NST-2];
  trig_t                      u2_q   [0:NST-2];
  trig_t                      ps_q   [1:NST-2];
  trig_t                      pc_q   [1:NST-2];
  logic signed [SC_W-1:0]     s_q;
  logic signed [SC_W-1:0]     c_q;
  trig_t                      u_d;

  // stage ready chain, a bubble is filled even when downstream stalls
  genvar k;
  generate
    for (k = 0; k < NST - 1; k++) begin : g_rdy
      assign rdy[k] = ~v_q[k] | rdy[k+1];
    end
  endgenerate
  assign rdy[NST-1] = ~v_q[NST-1] | rdy_i;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= v_i;
      for (int j = 1; j < NST; j++) begin
        if (rdy[j]) v_q[j] <= v_q[j-1];
      end
    end
  end

  // angle to q30 fraction of a quarter turn
  always_comb begin
    u_d = trig_t'(angle_i) <<< (31 - ANGLE_BITS);
  end

  // square of the angle
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      kind_q[0] <= kind_i;
      t_q[0]    <= t_i;
      z_q[0]    <= z_i;
      u_q[0]    <= u_d;
      u2_q[0]   <= mulq(u_d, u_d);
    end
  end

  // horner steps, one coefficient per stage
  generate
    for (k = 1; k <= NST - 2; k++) begin : g_horner
      trig_t ps_in;
      trig_t pc_in;
      if (k == 1) begin : g_first
        assign ps_in = sin_coef(3'd5);
        assign pc_in = cos_coef(3'd5);
      end else begin : g_next
        assign ps_in = ps_q[k-1];
        assign pc_in = pc_q[k-1];
      end
      always_ff @(posedge clk_i) begin
        if (rdy[k]) begin
          kind_q[k] <= kind_q[k-1];
          t_q[k]    <= t_q[k-1];
          z_q[k]    <= z_q[k-1];
          u_q[k]    <= u_q[k-1];
          u2_q[k]   <= u2_q[k-1];
          ps_q[k]   <= sin_coef(3'(5 - k)) - mulq(u2_q[k-1], ps_in);
          pc_q[k]   <= cos_coef(3'(5 - k)) - mulq(u2_q[k-1], pc_in);
        end
      end
    end
  endgenerate

  // final sine and cosine
  always_ff @(posedge clk_i) begin
    if (rdy[NST-1]) begin
      kind_q[NST-1] <= kind_q[NST-2];
      t_q[NST-1]    <= t_q[NST-2];
      z_q[NST-1]    <= z_q[NST-2];
      s_q           <= SC_W'(mulq(u_q[NST-2], ps_q[NST-2]));
      c_q           <= SC_W'(TRIG_ONE - mulq(u2_q[NST-2], pc_q[NST-2]));
    end
  end

  assign rdy_o  = rdy[0];
  assign v_o    = v_q[NST-1];
  assign kind_o = kind_q[NST-1];
  assign t_o    = t_q[NST-1];
  assign z_o    = z_q[NST-1];
  assign s_o    = s_q;
  assign c_o    = c_q;

endmodule

`default_nettype wire

>>> src/hcv_arith.sv
`timescale 1ns / 1ps
`default_nettype none

module hcv_arith import hcv_pkg::*; #(
  parameter int POS_BITS         = 22,
  parameter int RESULT_FRAC_BITS = 16,
  localparam int PW    = POS_BITS + SC_W,
  localparam int NW    = PW + 1,
  localparam int HW    = (NW + 1) / 2,
  localparam int SHIFT = TRIG_FRAC + POS_FRAC + RESULT_FRAC_BITS,
  localparam int XW    = 2 * HW + CST_W + SHIFT,
  localparam int D2W   = 4 * HW,
  localparam int YW    = D2W + FIELD_W
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [FIELD_W-1:0]         field_i,
  input  logic                       v_i,
  output logic                       rdy_o,
  input  logic                       kind_i,
  input  logic signed [POS_BITS-1:0] t_i,
  input  logic signed [POS_BITS-1:0] z_i,
  input  logic signed [SC_W-1:0]     s_i,
  input  logic signed [SC_W-1:0]     c_i,
  output logic                       v_o,
  input  logic                       rdy_i,
  output logic [XW-1:0]              x_o,
  output logic [YW-1:0]              y_o,
  output logic                       neg_o,
  output logic                       nz_o,
  output logic                       yz_o
);

  localparam int NST = 6;

  logic [NST-1:0] v_q;
  logic [NST-1:0] rdy;

  // stage 0
  logic signed [PW-1:0] zs_q, tc_q, ts_q, zc_q;
  logic                 kind0_q;
  // stage 1
  logic [NW-1:0]        mn_q, md_q;
  logic                 kind1_q, neg1_q, nz1_q;
  logic [FIELD_W-1:0]   vs1_q;
  // stage 2
  logic [HW+CST_W-1:0]  xa_q, xb_q;
  logic [2*HW-1:0]      d2a_q, d2b_q, d2c_q;
  logic                 neg2_q, nz2_q, yz2_q;
  logic [FIELD_W-1:0]   vs2_q;
  // stage 3
  logic [XW-1:0]        x3_q;
  logic [D2W-1:0]       d2_q;
  logic                 neg3_q, nz3_q, yz3_q;
  logic [FIELD_W-1:0]   vs3_q;
  // stage 4
  logic [XW-1:0]        x4_q;
  logic [HW+FIELD_W-1:0] ya_q [0:3];
  logic                 neg4_q, nz4_q, yz4_q;
  // stage 5
  logic [XW-1:0]        x5_q;
  logic [YW-1:0]        y5_q;
  logic                 neg5_q, nz5_q, yz5_q;

  logic signed [NW-1:0] num_d, den_d;
  logic [HW-1:0]        nh_d, nl_d, dh_d, dl_d;
  logic [CST_W-1:0]     cst_d;
  logic [YW-1:0]        y_d;

  // ready chain
  genvar k;
  generate
    for (k = 0; k < NST - 1; k++) begin : g_rdy
      assign rdy[k] = ~v_q[k] | rdy[k+1];
    end
  endgenerate
  assign rdy[NST-1] = ~v_q[NST-1] | rdy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= v_i;
      for (int j = 1; j < NST; j++) begin
        if (rdy[j]) v_q[j] <= v_q[j-1];
      end
    end
  end

  // position times sine and cosine
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      kind0_q <= kind_i;
      zs_q    <= PW'(z_i) * PW'(s_i);
      tc_q    <= PW'(t_i) * PW'(c_i);
      ts_q    <= PW'(t_i) * PW'(s_i);
      zc_q    <= PW'(z_i) * PW'(c_i);
    end
  end

  // numerator split into sign and magnitude, magnitude of the denominator
  always_comb begin
    num_d = NW'(zs_q) - NW'(tc_q);
    den_d = NW'(ts_q) + NW'(zc_q);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      kind1_q <= kind0_q;
      neg1_q  <= num_d[NW-1];
      nz1_q   <= (num_d != '0);
      mn_q    <= num_d[NW-1] ? NW'(-num_d) : NW'(num_d);
      md_q    <= den_d[NW-1] ? NW'(-den_d) : NW'(den_d);
      vs1_q   <= (kind0_q == KIND_LUT) ? field_i : FIELD_W'(1);
    end
  end

  // partial products of the scaled numerator and the squared denominator
  always_comb begin
    nh_d  = HW'(mn_q >> HW);
    nl_d  = mn_q[HW-1:0];
    dh_d  = HW'(md_q >> HW);
    dl_d  = md_q[HW-1:0];
    cst_d = (kind1_q == KIND_LUT) ? LUT_CONST : PRELUT_CONST;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      xa_q   <= (HW+CST_W)'(nh_d) * (HW+CST_W)'(cst_d);
      xb_q   <= (HW+CST_W)'(nl_d) * (HW+CST_W)'(cst_d);
      d2a_q  <= (2*HW)'(dh_d) * (2*HW)'(dh_d);
      d2b_q  <= (2*HW)'(dh_d) * (2*HW)'(dl_d);
      d2c_q  <= (2*HW)'(dl_d) * (2*HW)'(dl_d);
      neg2_q <= neg1_q;
      nz2_q  <= nz1_q;
      yz2_q  <= (md_q == '0) || (vs1_q == '0);
      vs2_q  <= vs1_q;
    end
  end

  // sum the partial products
  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      x3_q   <= (XW'(xa_q) << (HW + SHIFT)) + (XW'(xb_q) << SHIFT);
      d2_q   <= (D2W'(d2a_q) << (2 * HW)) + (D2W'(d2b_q) << (HW + 1)) + D2W'(d2c_q);
      neg3_q <= neg2_q;
      nz3_q  <= nz2_q;
      yz3_q  <= yz2_q;
      vs3_q  <= vs2_q;
    end
  end

  // squared denominator times the field value (one for prelut), by chunks
  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      x4_q   <= x3_q;
      neg4_q <= neg3_q;
      nz4_q  <= nz3_q;
      yz4_q  <= yz3_q;
      for (int j = 0; j < 4; j++) begin
        ya_q[j] <= (HW+FIELD_W)'(d2_q[j*HW +: HW]) * (HW+FIELD_W)'(vs3_q);
      end
    end
  end

  always_comb begin
    y_d = '0;
    for (int j = 0; j < 4; j++) begin
      y_d = y_d + (YW'(ya_q[j]) << (j * HW));
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      x5_q   <= x4_q;
      y5_q   <= y_d;
      neg5_q <= neg4_q;
      nz5_q  <= nz4_q;
      yz5_q  <= yz4_q;
    end
  end

  assign rdy_o = rdy[0];
  assign v_o   = v_q[NST-1];
  assign x_o   = x5_q;
  assign y_o   = y5_q;
  assign neg_o = neg5_q;
  assign nz_o  = nz5_q;
  assign yz_o  = yz5_q;

endmodule

`default_nettype wire

>>> src/hcv_div.sv
`timescale 1ns / 1ps
`default_nettype none

module hcv_div import hcv_pkg::*; #(
  parameter int XW = 141,
  parameter int YW = 136,
  localparam int CW = (XW > YW + Q_W) ? XW : YW + Q_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          v_i,
  output logic          rdy_o,
  input  logic [XW-1:0] x_i,
  input  logic [YW-1:0] y_i,
  input  logic          neg_i,
  input  logic          nz_i,
  input  logic          yz_i,
  output logic          v_o,
  input  logic          rdy_i,
  output logic [31:0]   curve_value_o,
  output logic          saturated_o
);

  localparam int NST = Q_W + 1;

  logic [NST-1:0] v_q;
  logic [NST-1:0] rdy;

  logic [XW-1:0]  r_q   [0:Q_W-1];
  logic [YW-1:0]  y_q   [0:Q_W-1];
  logic [Q_W-1:0] q_q   [0:Q_W-1];
  logic           neg_q [0:Q_W-1];
  logic           nz_q  [0:Q_W-1];
  logic           yz_q  [0:Q_W-1];

  logic [31:0]    res_q;
  logic           sat_q;

  logic [Q_W-1:0] lim_d, qf_d, qs_d;
  logic           over_d;

  genvar k;
  generate
    for (k = 0; k < NST - 1; k++) begin : g_rdy
      assign rdy[k] = ~v_q[k] | rdy[k+1];
    end
  endgenerate
  assign rdy[NST-1] = ~v_q[NST-1] | rdy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= v_i;
      for (int j = 1; j < NST; j++) begin
        if (rdy[j]) v_q[j] <= v_q[j-1];
      end
    end
  end

  // restoring division, one quotient bit per stage from the guard bit down
  generate
    for (k = 0; k < Q_W; k++) begin : g_step
      logic [XW-1:0]  r_in;
      logic [YW-1:0]  y_in;
      logic [Q_W-1:0] q_in;
      logic           neg_in, nz_in, yz_in;
      logic [CW-1:0]  sh;
      logic           ge;
      if (k == 0) begin : g_first
        assign r_in   = x_i;
        assign y_in   = y_i;
        assign q_in   = '0;
        assign neg_in = neg_i;
        assign nz_in  = nz_i;
        assign yz_in  = yz_i;
      end else begin : g_next
        assign r_in   = r_q[k-1];
        assign y_in   = y_q[k-1];
        assign q_in   = q_q[k-1];
        assign neg_in = neg_q[k-1];
        assign nz_in  = nz_q[k-1];
        assign yz_in  = yz_q[k-1];
      end
      assign sh = CW'(y_in) << (Q_W - 1 - k);
      assign ge = (CW'(r_in) >= sh);
      always_ff @(posedge clk_i) begin
        if (rdy[k]) begin
          r_q[k]   <= ge ? XW'(CW'(r_in) - sh) : r_in;
          q_q[k]   <= q_in | (Q_W'(ge) << (Q_W - 1 - k));
          y_q[k]   <= y_in;
          neg_q[k] <= neg_in;
          nz_q[k]  <= nz_in;
          yz_q[k]  <= yz_in;
        end
      end
    end
  endgenerate

  // saturation and sign
  always_comb begin
    lim_d  = neg_q[Q_W-1] ? 33'd2147483648 : 33'd2147483647;
    qf_d   = q_q[Q_W-1];
    over_d = qf_d[Q_W-1] || (qf_d > lim_d);
    if (yz_q[Q_W-1]) begin
      qs_d = nz_q[Q_W-1] ? lim_d : '0;
    end else if (over_d) begin
      qs_d = lim_d;
    end else begin
      qs_d = qf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NST-1]) begin
      res_q <= neg_q[Q_W-1] ? 32'(-qs_d[31:0]) : qs_d[31:0];
      sat_q <= yz_q[Q_W-1] | over_d;
    end
  end

  assign rdy_o         = rdy[0];
  assign v_o           = v_q[NST-1];
  assign curve_value_o = res_q;
  assign saturated_o   = sat_q;

endmodule

`default_nettype wire

>>> src/hcv_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module hcv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] curve_value_o,
  input logic        saturated_o
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(curve_value_o)
      && $stable(saturated_o))
    else $error("held result changed");

  // input stalls only when the pipe is full behind a stalled output
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // a saturated nonzero value is one of the two limits
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o && (curve_value_o != 32'h0) |->
      (curve_value_o == 32'h7fffffff) || (curve_value_o == 32'h80000000))
    else $error("saturated value off the limits");

  // no result once reset has been seen at an edge
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid in reset");

endmodule

bind hough_curve_value_core hcv_checker u_hcv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .curve_value_o (curve_value_o),
  .saturated_o   (saturated_o)
);

`default_nettype wire
